// ----- rtl/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and helpers for the HTTP request head parser
// Phase and method codes, byte roles, status codes, character classes and
// the header name that carries the body length.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // default width of the body length accumulator
  localparam int LENGTH_BITS_DEF = 32;

  // input opcodes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status
  localparam logic [1:0] STAT_INCOMPLETE = 2'd0;
  localparam logic [1:0] STAT_COMPLETE   = 2'd1;
  localparam logic [1:0] STAT_MALFORMED  = 2'd2;

  // byte roles
  localparam logic [2:0] ROLE_DELIM  = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_TARGET = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;
  localparam logic [2:0] ROLE_BODY   = 3'd5;

  // method match progress codes
  localparam logic [2:0] MP_NONE  = 3'd0;
  localparam logic [2:0] MP_P     = 3'd1;
  localparam logic [2:0] MP_PO    = 3'd2;
  localparam logic [2:0] MP_POS   = 3'd3;
  localparam logic [2:0] MP_POST  = 3'd4;
  localparam logic [2:0] MP_PU    = 3'd5;
  localparam logic [2:0] MP_PUT   = 3'd6;
  localparam logic [2:0] MP_FAIL  = 3'd7;

  // length of "Content-Length"
  localparam logic [3:0] CL_NAME_LEN = 4'd14;

  typedef enum logic [4:0] {
    PH_METHOD_START = 5'd0,
    PH_METHOD       = 5'd1,
    PH_TARGET       = 5'd2,
    PH_VER_H        = 5'd3,
    PH_VER_T1       = 5'd4,
    PH_VER_T2       = 5'd5,
    PH_VER_P        = 5'd6,
    PH_VER_SLASH    = 5'd7,
    PH_MAJOR_START  = 5'd8,
    PH_MAJOR        = 5'd9,
    PH_MINOR_START  = 5'd10,
    PH_MINOR        = 5'd11,
    PH_LF_1         = 5'd12,
    PH_LINE_START   = 5'd13,
    PH_FOLD         = 5'd14,
    PH_NAME         = 5'd15,
    PH_VALUE_SPACE  = 5'd16,
    PH_VALUE        = 5'd17,
    PH_LF_2         = 5'd18,
    PH_LF_3         = 5'd19,
    PH_BODY         = 5'd20,
    PH_GOOD         = 5'd21,
    PH_BAD          = 5'd22
  } phase_t;

  typedef enum logic [3:0] {
    METH_UNKNOWN = 4'd0,
    METH_GET     = 4'd1,
    METH_HEAD    = 4'd2,
    METH_POST    = 4'd3,
    METH_PUT     = 4'd4,
    METH_DELETE  = 4'd5,
    METH_CONNECT = 4'd6,
    METH_OPTIONS = 4'd7,
    METH_TRACE   = 4'd8
  } method_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  byte_role;
    logic [7:0]  echo_byte;
    logic [3:0]  meth_code;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [31:0] body_length;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
      "[", "]", "?", "=", "{", "}", " ", 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_special(c);
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // v * 10 + digit, saturating at 255
  function automatic logic [7:0] dec_sat8(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, c[3:0]};
    return (n > 12'd255) ? 8'hFF : n[7:0];
  endfunction

  // characters of "Content-Length"
  function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:  r = "C";
      4'd1:  r = "o";
      4'd2:  r = "n";
      4'd3:  r = "t";
      4'd4:  r = "e";
      4'd5:  r = "n";
      4'd6:  r = "t";
      4'd7:  r = "-";
      4'd8:  r = "L";
      4'd9:  r = "e";
      4'd10: r = "n";
      4'd11: r = "g";
      4'd12: r = "t";
      4'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/http_request_head_parser_unit.sv -----
// ----------------------------------------------------------------------------
// http_request_head_parser_unit: streaming HTTP/1.1 request head parser
// Per-byte parse of request line, headers, blank line and body length.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. The block takes one byte (or a
// restart) every cycle while in_stall is low: the whole parse step for a
// byte is a single pass of logic from the parser state registers to the
// result register or the skid register. A two-entry output
// buffer (result register plus skid register) lets the block take the next
// byte while a result is still waiting; in_stall rises only when both are
// full. Restart returns every piece of parser state to its reset value. No
// header or target text is stored; only method, version and the first
// Content-Length value are kept.
module http_request_head_parser_unit
  import hrhp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_byte_role,
  output logic [7:0]  out_echo_byte,
  output logic [3:0]  out_method_code,
  output logic [7:0]  out_version_major,
  output logic [7:0]  out_version_minor,
  output logic [31:0] out_body_length
);

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             first_char_r, first_char_nxt;
  logic [2:0]             match_prog_r, match_prog_nxt;
  method_t                method_r, method_nxt;
  logic                   have_hdr_r, have_hdr_nxt;
  logic [3:0]             name_idx_r, name_idx_nxt;
  logic                   name_ok_r, name_ok_nxt;
  logic                   len_found_r, len_found_nxt;
  logic                   digits_open_r, digits_open_nxt;
  logic [LENGTH_BITS-1:0] len_val_r, len_val_nxt;
  logic [LENGTH_BITS-1:0] body_rem_r, body_rem_nxt;
  logic [7:0]             major_r, major_nxt;
  logic [7:0]             minor_r, minor_nxt;

  // output buffer
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  result_t res;

  logic                   accept;
  logic                   take;
  logic [7:0]             c;
  logic [2:0]             role;
  logic                   name_hit;
  logic                   name_hit_first;
  logic [LENGTH_BITS+3:0] len_acc;
  logic [LENGTH_BITS-1:0] len_digit;
  logic [LENGTH_BITS-1:0] body_dec;
  logic [LENGTH_BITS+31:0] len_ext;

  assign accept = in_valid && !skid_valid_r;
  assign take   = out_valid_r && !out_stall;
  assign c      = in_data_byte;

  // Content-Length name compare
  assign name_hit       = name_ok_r && (name_idx_r < CL_NAME_LEN) &&
                          (c == cl_name_char(name_idx_r));
  assign name_hit_first = (c == cl_name_char(4'd0));

  // length * 10 + digit, saturating at the accumulator width
  assign len_acc   = {1'b0, len_val_r, 3'b000} + {3'b000, len_val_r, 1'b0} +
                     {{LENGTH_BITS{1'b0}}, c[3:0]};
  assign len_digit = (|len_acc[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                           : len_acc[LENGTH_BITS-1:0];
  assign body_dec  = body_rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  // per-byte parse step
  always_comb begin
    phase_nxt       = phase_r;
    first_char_nxt  = first_char_r;
    match_prog_nxt  = match_prog_r;
    method_nxt      = method_r;
    have_hdr_nxt    = have_hdr_r;
    name_idx_nxt    = name_idx_r;
    name_ok_nxt     = name_ok_r;
    len_found_nxt   = len_found_r;
    digits_open_nxt = digits_open_r;
    len_val_nxt     = len_val_r;
    body_rem_nxt    = body_rem_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    role            = ROLE_DELIM;

    if (in_opcode == OP_RESTART) begin
      phase_nxt       = PH_METHOD_START;
      first_char_nxt  = 8'd0;
      match_prog_nxt  = MP_NONE;
      method_nxt      = METH_UNKNOWN;
      have_hdr_nxt    = 1'b0;
      name_idx_nxt    = 4'd0;
      name_ok_nxt     = 1'b0;
      len_found_nxt   = 1'b0;
      digits_open_nxt = 1'b0;
      len_val_nxt     = '0;
      body_rem_nxt    = '0;
      major_nxt       = 8'd0;
      minor_nxt       = 8'd0;
    end else begin
      case (phase_r)
        PH_METHOD_START: begin
          if (!is_token(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            first_char_nxt = c;
            match_prog_nxt = (c == "P") ? MP_P : MP_FAIL;
            role           = ROLE_METHOD;
            phase_nxt      = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (c == " ") begin
            // first letter decides, else exact POST / PUT
            case (first_char_r)
              "G": method_nxt = METH_GET;
              "H": method_nxt = METH_HEAD;
              "D": method_nxt = METH_DELETE;
              "C": method_nxt = METH_CONNECT;
              "O": method_nxt = METH_OPTIONS;
              "T": method_nxt = METH_TRACE;
              default: begin
                if (match_prog_r == MP_POST)     method_nxt = METH_POST;
                else if (match_prog_r == MP_PUT) method_nxt = METH_PUT;
                else                             method_nxt = METH_UNKNOWN;
              end
            endcase
            phase_nxt = PH_TARGET;
          end else if (!is_token(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            if (match_prog_r == MP_P && c == "O")        match_prog_nxt = MP_PO;
            else if (match_prog_r == MP_PO && c == "S")  match_prog_nxt = MP_POS;
            else if (match_prog_r == MP_POS && c == "T") match_prog_nxt = MP_POST;
            else if (match_prog_r == MP_P && c == "U")   match_prog_nxt = MP_PU;
            else if (match_prog_r == MP_PU && c == "T")  match_prog_nxt = MP_PUT;
            else                                         match_prog_nxt = MP_FAIL;
            role = ROLE_METHOD;
          end
        end
        PH_TARGET: begin
          if (c == " ")        phase_nxt = PH_VER_H;
          else if (is_ctl(c))  phase_nxt = PH_BAD;
          else                 role = ROLE_TARGET;
        end
        PH_VER_H:  phase_nxt = (c == "H") ? PH_VER_T1 : PH_BAD;
        PH_VER_T1: phase_nxt = (c == "T") ? PH_VER_T2 : PH_BAD;
        PH_VER_T2: phase_nxt = (c == "T") ? PH_VER_P : PH_BAD;
        PH_VER_P:  phase_nxt = (c == "P") ? PH_VER_SLASH : PH_BAD;
        PH_VER_SLASH: begin
          if (c == "/") begin
            major_nxt = 8'd0;
            minor_nxt = 8'd0;
            phase_nxt = PH_MAJOR_START;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MAJOR_START: begin
          if (dec_digit(c)) begin
            major_nxt = dec_sat8(major_r, c);
            phase_nxt = PH_MAJOR;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MAJOR: begin
          if (c == ".")            phase_nxt = PH_MINOR_START;
          else if (dec_digit(c))   major_nxt = dec_sat8(major_r, c);
          else                     phase_nxt = PH_BAD;
        end
        PH_MINOR_START: begin
          if (dec_digit(c)) begin
            minor_nxt = dec_sat8(minor_r, c);
            phase_nxt = PH_MINOR;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MINOR: begin
          if (c == 8'h0D)          phase_nxt = PH_LF_1;
          else if (dec_digit(c))   minor_nxt = dec_sat8(minor_r, c);
          else                     phase_nxt = PH_BAD;
        end
        PH_LF_1: phase_nxt = (c == 8'h0A) ? PH_LINE_START : PH_BAD;
        PH_LINE_START: begin
          if (c == 8'h0D) begin
            phase_nxt = PH_LF_3;
          end else if (have_hdr_r && (c == " " || c == 8'h09)) begin
            phase_nxt = PH_FOLD;
          end else if (!is_token(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            // new header name; compare from the first character
            have_hdr_nxt = 1'b1;
            if (!len_found_r && name_hit_first) begin
              name_idx_nxt = 4'd1;
              name_ok_nxt  = 1'b1;
            end else begin
              name_idx_nxt = 4'd0;
              name_ok_nxt  = 1'b0;
            end
            role      = ROLE_NAME;
            phase_nxt = PH_NAME;
          end
        end
        PH_FOLD: begin
          if (c == 8'h0D) begin
            phase_nxt = PH_LF_2;
          end else if (c == " " || c == 8'h09) begin
            phase_nxt = PH_FOLD;
          end else if (is_ctl(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            if (digits_open_r) begin
              if (dec_digit(c)) len_val_nxt = len_digit;
              else              digits_open_nxt = 1'b0;
            end
            role      = ROLE_VALUE;
            phase_nxt = PH_VALUE;
          end
        end
        PH_NAME: begin
          if (c == ":") begin
            if (name_ok_r && name_idx_r == CL_NAME_LEN && !len_found_r) begin
              len_found_nxt   = 1'b1;
              digits_open_nxt = 1'b1;
              len_val_nxt     = '0;
            end
            name_ok_nxt = 1'b0;
            phase_nxt   = PH_VALUE_SPACE;
          end else if (!is_token(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            if (name_hit) name_idx_nxt = name_idx_r + 4'd1;
            else          name_ok_nxt  = 1'b0;
            role = ROLE_NAME;
          end
        end
        PH_VALUE_SPACE: phase_nxt = (c == " ") ? PH_VALUE : PH_BAD;
        PH_VALUE: begin
          if (c == 8'h0D) begin
            digits_open_nxt = 1'b0;
            phase_nxt       = PH_LF_2;
          end else if (is_ctl(c)) begin
            phase_nxt = PH_BAD;
          end else begin
            if (digits_open_r) begin
              if (dec_digit(c)) len_val_nxt = len_digit;
              else              digits_open_nxt = 1'b0;
            end
            role = ROLE_VALUE;
          end
        end
        PH_LF_2: begin
          digits_open_nxt = 1'b0;
          phase_nxt       = (c == 8'h0A) ? PH_LINE_START : PH_BAD;
        end
        PH_LF_3: begin
          if (c != 8'h0A) begin
            phase_nxt = PH_BAD;
          end else if (len_val_r != '0) begin
            body_rem_nxt = len_val_r;
            phase_nxt    = PH_BODY;
          end else begin
            phase_nxt = PH_GOOD;
          end
        end
        PH_BODY: begin
          role = ROLE_BODY;
          if (body_rem_r != '0) body_rem_nxt = body_dec;
          phase_nxt = (body_rem_nxt == '0) ? PH_GOOD : PH_BODY;
        end
        PH_GOOD: phase_nxt = PH_GOOD;
        default: phase_nxt = PH_BAD;
      endcase
      if (phase_nxt == PH_BAD) role = ROLE_DELIM;
    end
  end

  // body length, saturated to the 32-bit field
  assign len_ext = {32'd0, len_val_nxt};

  // result item for this byte
  always_comb begin
    if (phase_nxt == PH_GOOD)     res.status = STAT_COMPLETE;
    else if (phase_nxt == PH_BAD) res.status = STAT_MALFORMED;
    else                          res.status = STAT_INCOMPLETE;
    res.byte_role     = role;
    res.echo_byte     = (in_opcode == OP_RESTART) ? 8'd0 : c;
    res.meth_code     = method_nxt;
    res.version_major = major_nxt;
    res.version_minor = minor_nxt;
    res.body_length   = (|len_ext[LENGTH_BITS+31:32]) ? 32'hFFFF_FFFF : len_ext[31:0];
  end

  // output buffer: result register with skid register behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt      = res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_METHOD_START;
      first_char_r  <= 8'd0;
      match_prog_r  <= MP_NONE;
      method_r      <= METH_UNKNOWN;
      have_hdr_r    <= 1'b0;
      name_idx_r    <= 4'd0;
      name_ok_r     <= 1'b0;
      len_found_r   <= 1'b0;
      digits_open_r <= 1'b0;
      len_val_r     <= '0;
      body_rem_r    <= '0;
      major_r       <= 8'd0;
      minor_r       <= 8'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      first_char_r  <= first_char_nxt;
      match_prog_r  <= match_prog_nxt;
      method_r      <= method_nxt;
      have_hdr_r    <= have_hdr_nxt;
      name_idx_r    <= name_idx_nxt;
      name_ok_r     <= name_ok_nxt;
      len_found_r   <= len_found_nxt;
      digits_open_r <= digits_open_nxt;
      len_val_r     <= len_val_nxt;
      body_rem_r    <= body_rem_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
    end
  end

  // output valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall          = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_status        = main_r.status;
  assign out_byte_role     = main_r.byte_role;
  assign out_echo_byte     = main_r.echo_byte;
  assign out_method_code   = main_r.meth_code;
  assign out_version_major = main_r.version_major;
  assign out_version_minor = main_r.version_minor;
  assign out_body_length   = main_r.body_length;

endmodule
